// File: src/arma_pkg.sv
package arma_pkg;

  // Page numbers are 20 bits wide throughout.
  localparam int unsigned PAGE_W = 20;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_ALLOCATE  = 2'd1,
    OP_RESERVE   = 2'd2,
    OP_UNRESERVE = 2'd3
  } op_e;

  // Region kinds.
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_RESERVED = 2'd1;

  // Status codes of a response.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERLAP   = 3'd1;
  localparam logic [2:0] ST_NO_ROOM   = 3'd2;
  localparam logic [2:0] ST_UNALIGNED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Configuration register indexes.
  localparam logic REG_CEILING  = 1'b0;
  localparam logic REG_DEF_PRIV = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PAGE_W-1:0] begin_page;
    logic [PAGE_W-1:0] end_page;
    logic [1:0]        area_kind;
    logic              area_privilege;
    logic              area_writable;
    logic [31:0]       size_bytes;
    logic [PAGE_W-1:0] address_page;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PAGE_W-1:0] result_page;
  } rsp_t;

  // One entry of the region table.
  typedef struct packed {
    logic [PAGE_W-1:0] begin_page;
    logic [PAGE_W-1:0] end_page;
    logic [1:0]        kind;
    logic              priv;
    logic              writable;
  } region_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLAN,
    S_PREP,
    S_OPEN,
    S_CLOSE,
    S_FINAL,
    S_RESP
  } state_e;

  // Table move that a request needs.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_OPEN,
    SH_CLOSE
  } shift_e;

endpackage

// File: src/arma_ram.sv
module arma_ram
  import arma_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  region_t       wdata_i,
  input  logic [AW-1:0] raddr_i,
  output region_t       rdata_o
);

  region_t mem [DEPTH];
  region_t rdata_q;

  // One write port and one registered read port; a read sees the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/address_region_map_allocator_top.sv
// Channel   | Valid / ready            | Payload
// ----------+--------------------------+--------------------------------
// request   | in_valid_i / in_ready_o  | in_req_i (req_t)
// response  | out_valid_o / out_ready_i| out_rsp_o (rsp_t)
// config    | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// A request makes one pass over the table through the single read port of the region
// memory up to the change point, then, where the edit needs it, a shift of the entries
// behind it at one entry per cycle, then one write unless it is an unreserve. The next
// request can be taken in the cycle after the response is loaded. Requests refused by
// the field checks go from acceptance straight to the response state. Reset empties
// the table at once. A response that is not taken holds the block before its next
// response, but the next request is taken meanwhile.
module address_region_map_allocator_top
  import arma_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned PAGE_BITS   = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_rsp_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  state_e state_q, state_d;
  req_t req_q;
  logic [CNT_W-1:0] count_q, idx_q, pos_q, sh_q, sp_q, cnt_nx_q;
  region_t prev_q, nxt_q, wrec_q;
  logic nxt_v_q, wen_q;
  logic [IDX_W-1:0] wa_q;
  shift_e shift_q;
  logic [2:0] status_q;
  logic [PAGE_W-1:0] page_q;
  logic out_valid_q;
  rsp_t out_rsp_q;
  logic [PAGE_W-1:0] ceiling_q;
  logic defpriv_q;

  logic mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  region_t mem_wd, rdata;

  arma_ram #(
    .DEPTH (MAX_REGIONS),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (rdata)
  );

  function automatic logic match_f(region_t a, region_t b);
    return (a.kind == KIND_DATA) && (b.kind == KIND_DATA) && (a.end_page == b.begin_page) &&
           (a.priv == b.priv) && (a.writable == b.writable);
  endfunction

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // Checks that need no table access.
  logic early_err;
  logic [2:0] early_status;
  always_comb begin
    early_err    = 1'b1;
    early_status = ST_OK;
    if (in_req_i.operation == OP_INSERT) begin
      if (in_req_i.end_page > ceiling_q) begin
        early_status = ST_NO_ROOM;
      end else if (in_req_i.end_page < in_req_i.begin_page) begin
        early_status = ST_OVERLAP;
      end else if (count_q >= MAX_CNT) begin
        early_status = ST_FULL;
      end else begin
        early_err = 1'b0;
      end
    end else if ((in_req_i.operation == OP_ALLOCATE) || (in_req_i.operation == OP_RESERVE)) begin
      if (in_req_i.size_bytes[PAGE_BITS-1:0] != '0) begin
        early_status = ST_UNALIGNED;
      end else begin
        early_err = 1'b0;
      end
    end else begin
      early_err = 1'b0;
    end
  end

  // Scan step: the entry at idx_q sits in rdata, prev_q holds the one before.
  logic [31:0] pages;
  logic at_end, scan_plan, scan_fail;
  logic [2:0] scan_status;
  logic [PAGE_W-1:0] bound, gap;
  assign pages  = req_q.size_bytes >> PAGE_BITS;
  assign at_end = (idx_q == count_q);
  assign bound  = at_end ? ceiling_q : rdata.begin_page;
  assign gap    = (bound > prev_q.end_page) ? (bound - prev_q.end_page) : '0;

  always_comb begin
    scan_plan   = 1'b0;
    scan_fail   = 1'b0;
    scan_status = ST_OK;
    unique case (req_q.operation)
      OP_INSERT: begin
        scan_plan = at_end || (rdata.begin_page >= req_q.begin_page);
      end
      OP_ALLOCATE, OP_RESERVE: begin
        scan_plan   = (idx_q != '0) && (32'(gap) >= pages);
        scan_fail   = at_end && !scan_plan;
        scan_status = ST_NO_ROOM;
      end
      default: begin
        scan_status = ST_NOT_FOUND;
        if (at_end) begin
          scan_fail = 1'b1;
        end else if (rdata.begin_page == req_q.address_page) begin
          if ((req_q.address_page != '0) && (rdata.kind == KIND_RESERVED)) begin
            scan_plan = 1'b1;
          end else begin
            scan_fail = 1'b1;
          end
        end
      end
    endcase
  end

  // Work out the table edit from the entries around the change point.
  region_t new_r, n1_r, p1_r, h1_r;
  logic m1, m2;
  logic plan_fail, plan_wen;
  logic [2:0] plan_status;
  logic [PAGE_W-1:0] plan_page;
  shift_e plan_shift;
  logic [CNT_W-1:0] plan_wa, plan_cnt, pos_m1;
  region_t plan_wrec;

  assign pos_m1 = pos_q - ONE;

  always_comb begin
    new_r      = '0;
    n1_r       = '0;
    p1_r       = '0;
    h1_r       = '0;
    m1         = 1'b0;
    m2         = 1'b0;
    plan_fail  = 1'b0;
    plan_wen   = 1'b1;
    plan_status = ST_OK;
    plan_page  = '0;
    plan_shift = SH_NONE;
    plan_wa    = pos_q;
    plan_cnt   = count_q;
    plan_wrec  = '0;
    unique case (req_q.operation)
      OP_INSERT: begin
        new_r = '{begin_page: req_q.begin_page, end_page: req_q.end_page,
                  kind: req_q.area_kind, priv: req_q.area_privilege,
                  writable: req_q.area_writable};
        if ((nxt_v_q && (nxt_q.begin_page < req_q.end_page)) ||
            ((pos_q != '0) && (req_q.begin_page < prev_q.end_page))) begin
          plan_fail   = 1'b1;
          plan_status = ST_OVERLAP;
        end
        m1 = nxt_v_q && match_f(new_r, nxt_q);
        n1_r = new_r;
        if (m1) begin
          n1_r.end_page = nxt_q.end_page;
        end
        m2 = (pos_q != '0) && match_f(prev_q, n1_r);
        p1_r = prev_q;
        p1_r.end_page = n1_r.end_page;
        if (m2) begin
          plan_wa   = pos_m1;
          plan_wrec = p1_r;
          if (m1) begin
            plan_shift = SH_CLOSE;
            plan_cnt   = count_q - ONE;
          end
        end else begin
          plan_wrec = n1_r;
          if (!m1) begin
            plan_shift = SH_OPEN;
            plan_cnt   = count_q + ONE;
          end
        end
      end
      OP_ALLOCATE, OP_RESERVE: begin
        plan_page = prev_q.end_page;
        h1_r = prev_q;
        h1_r.end_page = prev_q.end_page + pages[PAGE_W-1:0];
        new_r = '{begin_page: prev_q.end_page, end_page: h1_r.end_page,
                  kind: (req_q.operation == OP_ALLOCATE) ? KIND_DATA : KIND_RESERVED,
                  priv: defpriv_q, writable: 1'b1};
        if ((req_q.operation == OP_ALLOCATE) && (prev_q.kind == KIND_DATA)) begin
          // Grow the data region in front of the gap.
          m1 = nxt_v_q && match_f(h1_r, nxt_q);
          plan_wa   = pos_m1;
          plan_wrec = h1_r;
          if (m1) begin
            plan_wrec.end_page = nxt_q.end_page;
            plan_shift = SH_CLOSE;
            plan_cnt   = count_q - ONE;
          end
        end else if (count_q >= MAX_CNT) begin
          plan_fail   = 1'b1;
          plan_status = ST_FULL;
          plan_page   = '0;
        end else begin
          m1 = (req_q.operation == OP_ALLOCATE) && nxt_v_q && match_f(new_r, nxt_q);
          plan_wrec = new_r;
          if (m1) begin
            plan_wrec.end_page = nxt_q.end_page;
          end else begin
            plan_shift = SH_OPEN;
            plan_cnt   = count_q + ONE;
          end
        end
      end
      default: begin
        plan_wen   = 1'b0;
        plan_shift = SH_CLOSE;
        plan_cnt   = count_q - ONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = early_err ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_plan) begin
          state_d = S_PLAN;
        end else if (scan_fail) begin
          state_d = S_RESP;
        end
      end
      S_PLAN: begin
        if (plan_fail) begin
          state_d = S_RESP;
        end else if (plan_shift != SH_NONE) begin
          state_d = S_PREP;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_PREP: state_d = (shift_q == SH_OPEN) ? S_OPEN : S_CLOSE;
      S_OPEN: begin
        if (sh_q <= sp_q) begin
          state_d = S_FINAL;
        end
      end
      S_CLOSE: begin
        if ((sh_q + ONE) >= count_q) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: state_d = S_RESP;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port control and handshake outputs.
  logic [CNT_W-1:0] ra_full;
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    mem_we  = 1'b0;
    mem_wa  = sh_q[IDX_W-1:0];
    mem_wd  = rdata;
    ra_full = '0;
    unique case (state_q)
      S_SCAN: ra_full = idx_q + ONE;
      S_PREP: ra_full = (shift_q == SH_OPEN) ? (count_q - ONE) : (sp_q + ONE);
      S_OPEN: begin
        ra_full = sh_q - CNT_W'(2);
        mem_we  = (sh_q > sp_q);
      end
      S_CLOSE: begin
        ra_full = sh_q + CNT_W'(2);
        mem_we  = ((sh_q + ONE) < count_q);
      end
      S_FINAL: begin
        mem_we = wen_q;
        mem_wa = wa_q;
        mem_wd = wrec_q;
      end
      default: ra_full = '0;
    endcase
    mem_ra = ra_full[IDX_W-1:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ceiling_q   <= '1;
      defpriv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FINAL) begin
        count_q <= cnt_nx_q;
      end
      if ((state_q == S_RESP) && (state_d == S_IDLE)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CEILING) begin
          ceiling_q <= cfg_wdata_i;
        end else begin
          defpriv_q <= cfg_wdata_i[0];
        end
      end
    end
  end

  // Request, scan and edit registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q    <= in_req_i;
          idx_q    <= '0;
          status_q <= early_status;
          page_q   <= '0;
        end
      end
      S_SCAN: begin
        if (scan_plan) begin
          nxt_q   <= rdata;
          nxt_v_q <= !at_end;
          pos_q   <= idx_q;
        end else if (scan_fail) begin
          status_q <= scan_status;
        end else begin
          prev_q <= rdata;
          idx_q  <= idx_q + ONE;
        end
      end
      S_PLAN: begin
        status_q <= plan_status;
        page_q   <= plan_page;
        shift_q  <= plan_shift;
        sp_q     <= pos_q;
        wa_q     <= plan_wa[IDX_W-1:0];
        wrec_q   <= plan_wrec;
        wen_q    <= plan_wen;
        cnt_nx_q <= plan_cnt;
      end
      S_PREP: sh_q <= (shift_q == SH_OPEN) ? count_q : sp_q;
      S_OPEN: sh_q <= sh_q - ONE;
      S_CLOSE: sh_q <= sh_q + ONE;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_rsp_q <= '{status: status_q, result_page: page_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: src/arma_checker.sv
module arma_checker
  import arma_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is in work");

  // A response never shows up in the cycle right after a request is taken.
  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("response appeared too early");

  // A failed request grants no page.
  a_fail_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_OK)) |-> (out_rsp_o.result_page == '0))
    else $error("page granted on failure");

  // A response waits until it is taken.
  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("response dropped or changed while stalled");

endmodule

bind address_region_map_allocator_top arma_checker u_arma_checker (.*);
